### rtl/nce_pkg.sv
`timescale 1ns / 1ps
// Package: shared types and constants for the nibble CPU executor
package nce_pkg;

   typedef enum logic [1:0] {
      KIND_OP = 2'd0,
      KIND_IM = 2'd1,
      KIND_IN = 2'd2
   } cycle_kind_type;

   typedef enum logic [1:0] {
      PORT_NONE = 2'd0,
      PORT_ROM  = 2'd1,
      PORT_RAM  = 2'd2
   } port_kind_type;

   localparam logic [11:0] STATUS_MASK = 12'h7f0;
   localparam logic [11:0] ADDR_MASK   = 12'hfff;
   localparam logic [12:0] BANK_FLAG   = 13'h1000;
   localparam logic [3:0]  DAA_ADJUST  = 4'd6;
   localparam logic [3:0]  DAA_LIMIT   = 4'd9;

   function automatic logic [3:0] kbp_map(input logic [3:0] a);
      case (a)
         4'h0: kbp_map = 4'h0;
         4'h1: kbp_map = 4'h1;
         4'h2: kbp_map = 4'h2;
         4'h4: kbp_map = 4'h3;
         4'h8: kbp_map = 4'h4;
         default: kbp_map = 4'hf;
      endcase
   endfunction

endpackage

### rtl/nce_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read
module nce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

### rtl/nibble_cpu_instruction_executor_unit.sv
`timescale 1ns / 1ps
// Top level: nibble CPU instruction executor
//
// Input channel req_ carries one fetched code byte (with TEST level and the
// ROM input port nibble) per machine cycle; result channel rsp_ returns the
// next fetch address, any port write, the accumulator and carry.
// csr_wr_en / csr_wr_data select 4004 (0) or 4040 (1) mode; write only idle.
// The data RAM (a synchronous memory holding memory and status characters) is
// read at the transfer edge, as the item enters stage 1; the item then executes
// and writes back into the result register once that register is free or drains.
// A new item is taken each cycle while rsp_ready holds and no clearing pass
// runs; RAM accesses of consecutive items are forwarded, so one item
// per cycle is sustained. After reset a clearing pass zeroes the data RAM;
// no item is accepted during it. A stalled result is held in the output
// register and the block keeps nothing else in flight behind it beyond one item.
module nibble_cpu_instruction_executor_unit
   import nce_pkg::*;
#(
   parameter int STACK_DEPTH = 8,
   parameter int INDEX_PAIRS = 12,
   parameter int DATA_WORDS  = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_code_byte,
   input  logic        req_test_level,
   input  logic [3:0]  req_port_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [12:0] rsp_next_fetch_address,
   output logic [1:0]  rsp_port_write_kind,
   output logic [11:0] rsp_port_address,
   output logic [3:0]  rsp_port_data,
   output logic [3:0]  rsp_accumulator_out,
   output logic        rsp_carry_out
);
   localparam int AW  = $clog2(DATA_WORDS);
   localparam int SPW = $clog2(STACK_DEPTH);
   localparam int PW  = $clog2(INDEX_PAIRS);

   logic variant_ff;
   logic [3:0] acc_ff, acc_in;
   logic carry_ff, carry_in;
   logic [11:0] stack_ff [STACK_DEPTH];
   logic [11:0] stack_in [STACK_DEPTH];
   logic [SPW-1:0] sp_ff, sp_in;
   logic [7:0] pairs_ff [INDEX_PAIRS];
   logic [7:0] pairs_in [INDEX_PAIRS];
   logic bank_ff, bank_in;
   logic [3:0] cmd_ff, cmd_in;
   logic [3:0] pend_ff, pend_in;
   logic [7:0] ramaddr_ff, ramaddr_in;
   cycle_kind_type kind_ff, kind_in;
   logic [7:0] held_ff, held_in;
   logic [11:0] fp_ff, fp_in;

   // stage 1: item waiting for RAM read
   logic s1_valid_ff;
   logic [7:0] s1_code_ff;
   logic s1_test_ff;
   logic [3:0] s1_pin_ff;
   // result register
   logic out_valid_ff;
   logic [12:0] o_fa_ff;
   logic [1:0] o_kind_ff;
   logic [11:0] o_pa_ff;
   logic [3:0] o_pd_ff, o_acc_ff;
   logic o_c_ff;

   logic clearing_ff;
   logic [AW-1:0] clr_ff;

   // RAM
   logic ram_we;
   logic [AW-1:0] ram_wa, ram_ra;
   logic [7:0] ram_wd, ram_rd;
   logic fwd_ff;
   logic [7:0] fwd_data_ff;
   logic [7:0] ram_q;

   nce_ram #(.WIDTH(8), .DEPTH(DATA_WORDS)) u_ram (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
      .rd_addr(ram_ra), .rd_data(ram_rd)
   );

   // execution happens in stage 1 when the result slot is free
   logic exec;
   assign exec = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !clearing_ff && (!s1_valid_ff || exec);

   // read address for the item being accepted, computed from state after
   // the executing item; only I/O opcodes in opcode cycles touch the RAM.
   // Address state (cmd, ramaddr) after exec is the _in values.
   logic [AW-1:0] mi_next, si_next, new_addr;
   logic [11:0] st_raw;
   assign mi_next = AW'({cmd_in[2:0], ramaddr_in});
   assign st_raw  = (({cmd_in, ramaddr_in}) & STATUS_MASK) | {10'd0, req_code_byte[1:0]};
   assign si_next = AW'(st_raw);
   assign new_addr = (req_code_byte[3:2] == 2'b01 || req_code_byte[3:2] == 2'b11) ?
                     si_next : mi_next;

   // stage1 address (state is current)
   logic [AW-1:0] mi_cur, si_cur, acc_addr;
   logic [11:0] st_cur;
   assign mi_cur = AW'({cmd_ff[2:0], ramaddr_ff});
   assign st_cur = (({cmd_ff, ramaddr_ff}) & STATUS_MASK) | {10'd0, s1_code_ff[1:0]};
   assign si_cur = AW'(st_cur);
   assign acc_addr = (s1_code_ff[3:2] == 2'b01 || s1_code_ff[3:2] == 2'b11) ?
                     si_cur : mi_cur;
   // a held item keeps its own address on the read port
   assign ram_ra = (s1_valid_ff && !exec) ? acc_addr : new_addr;
   assign ram_q = fwd_ff ? fwd_data_ff : ram_rd;

   // pair slot helper
   function automatic logic [PW-1:0] slot(input logic [2:0] n, input logic bk,
                                          input logic var_);
      logic [3:0] idx;
      idx = {1'b0, n};
      if (!n[2] && bk && var_ && (32'(idx) + 8 < INDEX_PAIRS)) idx = idx + 4'd8;
      slot = PW'(idx);
   endfunction

   logic [3:0] opr, opa;
   logic [PW-1:0] ps, ps0, ps_held;
   logic [7:0] pr;
   logic [3:0] rg;
   logic [SPW-1:0] spn, sp_dec, sp_inc;
   logic [11:0] pc, pc_inc;
   logic jump;
   logic [4:0] sum;
   logic [1:0] pk;
   logic [11:0] pa;
   logic [3:0] pd;
   logic [SPW:0] depth;
   logic [3:0] tmp4;

   always_comb begin
      depth = variant_ff ? (SPW+1)'(STACK_DEPTH) : (SPW+1)'(4);
      spn = sp_ff;
      if ({1'b0, sp_ff} >= depth) spn = SPW'({1'b0, sp_ff} - depth);
      acc_in = acc_ff; carry_in = carry_ff;
      stack_in = stack_ff; sp_in = spn;
      pairs_in = pairs_ff; bank_in = bank_ff; cmd_in = cmd_ff; pend_in = pend_ff;
      ramaddr_in = ramaddr_ff; kind_in = kind_ff; held_in = held_ff; fp_in = fp_ff;
      ram_we = 1'b0; ram_wa = acc_addr; ram_wd = ram_q;
      pk = PORT_NONE; pa = 12'd0; pd = 4'd0;
      opr = 4'd0; opa = 4'd0; ps = '0; pr = 8'd0; rg = 4'd0; pc = 12'd0; pc_inc = 12'd0;
      jump = 1'b0; sum = 5'd0; tmp4 = 4'd0;
      sp_dec = ({1'b0, spn} == 0) ? SPW'(depth - 1) : spn - 1'b1;
      sp_inc = ({1'b0, spn} + 1 >= depth) ? '0 : spn + 1'b1;
      ps0 = slot(3'd0, bank_ff, variant_ff);
      ps_held = slot(held_ff[3:1], bank_ff, variant_ff);
      if (clearing_ff) begin
         ram_we = 1'b1; ram_wa = clr_ff; ram_wd = 8'd0;
      end
      if (exec) begin
         pc = stack_ff[spn];
         pc_inc = pc + 12'd1;
         if (kind_ff == KIND_IM) begin
            opr = held_ff[7:4]; opa = held_ff[3:0];
            ps = ps_held; pr = pairs_ff[ps];
            rg = opa[0] ? pr[3:0] : pr[7:4];
            stack_in[spn] = pc_inc; fp_in = pc_inc;
            kind_in = KIND_OP;
            case (opr)
               4'h1: begin
                  jump = (opa[0] && !s1_test_ff) || (opa[1] && carry_ff) ||
                         (opa[2] && acc_ff == 4'd0);
                  if (opa[3] != jump) begin
                     stack_in[spn] = {pc_inc[11:8], s1_code_ff}; fp_in = stack_in[spn];
                  end
               end
               4'h2: pairs_in[ps] = s1_code_ff;
               4'h4: begin
                  stack_in[spn] = {opa, s1_code_ff}; fp_in = {opa, s1_code_ff};
               end
               4'h5: begin
                  sp_in = sp_inc;
                  stack_in[sp_inc] = {opa, s1_code_ff}; fp_in = {opa, s1_code_ff};
               end
               4'h7: begin
                  tmp4 = rg + 4'd1;
                  if (opa[0]) pairs_in[ps] = {pr[7:4], tmp4};
                  else        pairs_in[ps] = {tmp4, pr[3:0]};
                  if (tmp4 != 4'd0) begin
                     stack_in[spn] = {pc_inc[11:8], s1_code_ff}; fp_in = stack_in[spn];
                  end
               end
               default: ;
            endcase
         end else if (kind_ff == KIND_IN) begin
            pairs_in[ps_held] = s1_code_ff;
            fp_in = pc;
            kind_in = KIND_OP;
         end else begin
            opr = s1_code_ff[7:4]; opa = s1_code_ff[3:0];
            held_in = s1_code_ff;
            stack_in[spn] = pc_inc; fp_in = pc_inc;
            kind_in = KIND_OP;
            ps = slot(opa[3:1], bank_ff, variant_ff); pr = pairs_ff[ps];
            rg = opa[0] ? pr[3:0] : pr[7:4];
            case (opr)
               4'h0: if (variant_ff) begin
                  ps = slot({2'b01, opa[1]}, bank_ff, variant_ff);
                  pr = pairs_ff[ps];
                  rg = opa[0] ? pr[3:0] : pr[7:4];
                  case (opa)
                     4'h3: acc_in = cmd_ff;
                     4'h4, 4'h5: acc_in = acc_ff | rg;
                     4'h6, 4'h7: acc_in = acc_ff & rg;
                     4'h8, 4'h9: pend_in = {pend_ff[3:1], opa[0]};
                     4'ha, 4'hb: bank_in = opa[0];
                     default: ;
                  endcase
               end
               4'h1, 4'h4, 4'h5, 4'h7: kind_in = KIND_IM;
               4'h2: if (opa[0]) ramaddr_in = pr; else kind_in = KIND_IM;
               4'h3: if (opa[0]) begin
                  stack_in[spn] = {pc_inc[11:8], pr}; fp_in = stack_in[spn];
               end else begin
                  fp_in = {pc_inc[11:8], pairs_ff[ps0]};
                  kind_in = KIND_IN;
               end
               4'h6: begin
                  tmp4 = rg + 4'd1;
                  if (opa[0]) pairs_in[ps] = {pr[7:4], tmp4};
                  else        pairs_in[ps] = {tmp4, pr[3:0]};
               end
               4'h8: begin
                  sum = {1'b0, acc_ff} + {1'b0, rg} + {4'd0, carry_ff};
                  acc_in = sum[3:0]; carry_in = sum[4];
               end
               4'h9: begin
                  sum = {1'b0, acc_ff} + {1'b0, ~rg} + {4'd0, ~carry_ff};
                  acc_in = sum[3:0]; carry_in = sum[4];
               end
               4'ha: acc_in = rg;
               4'hb: begin
                  acc_in = rg;
                  if (opa[0]) pairs_in[ps] = {pr[7:4], acc_ff};
                  else        pairs_in[ps] = {acc_ff, pr[3:0]};
               end
               4'hc: begin
                  sp_in = sp_dec; fp_in = stack_ff[sp_dec]; acc_in = opa;
               end
               4'hd: acc_in = opa;
               4'he: begin
                  case (opa)
                     4'h0: begin
                        ram_we = 1'b1; ram_wd = {ram_q[7:4], acc_ff};
                     end
                     4'h1, 4'h2: begin
                        pk = (opa == 4'h1) ? PORT_RAM : PORT_ROM;
                        pa = {cmd_ff, ramaddr_ff}; pd = acc_ff;
                     end
                     4'h4, 4'h5, 4'h6, 4'h7: begin
                        ram_we = 1'b1; ram_wd = {acc_ff, ram_q[3:0]};
                     end
                     4'h8: begin
                        sum = {1'b0, acc_ff} + {1'b0, ~ram_q[3:0]} + {4'd0, ~carry_ff};
                        acc_in = sum[3:0]; carry_in = sum[4];
                     end
                     4'h9: acc_in = ram_q[3:0];
                     4'ha: acc_in = s1_pin_ff;
                     4'hb: begin
                        sum = {1'b0, acc_ff} + {1'b0, ram_q[3:0]} + {4'd0, carry_ff};
                        acc_in = sum[3:0]; carry_in = sum[4];
                     end
                     4'hc, 4'hd, 4'he, 4'hf: acc_in = ram_q[7:4];
                     default: ;
                  endcase
               end
               4'hf: begin
                  case (opa)
                     4'h0: begin acc_in = 4'd0; carry_in = 1'b0; end
                     4'h1: carry_in = 1'b0;
                     4'h2: begin
                        sum = {1'b0, acc_ff} + 5'd1;
                        acc_in = sum[3:0]; carry_in = sum[4];
                     end
                     4'h3: carry_in = ~carry_ff;
                     4'h4: acc_in = ~acc_ff;
                     4'h5: begin acc_in = {acc_ff[2:0], carry_ff}; carry_in = acc_ff[3]; end
                     4'h6: begin acc_in = {carry_ff, acc_ff[3:1]}; carry_in = acc_ff[0]; end
                     4'h7: begin acc_in = {3'd0, carry_ff}; carry_in = 1'b0; end
                     4'h8: begin
                        sum = {1'b0, acc_ff} + 5'hf;
                        acc_in = sum[3:0]; carry_in = sum[4];
                     end
                     4'h9: begin acc_in = DAA_LIMIT + {3'd0, carry_ff}; carry_in = 1'b0; end
                     4'ha: carry_in = 1'b1;
                     4'hb: if (carry_ff || acc_ff > DAA_LIMIT) begin
                        sum = {1'b0, acc_ff} + {1'b0, DAA_ADJUST};
                        acc_in = sum[3:0];
                        if (sum[4]) carry_in = 1'b1;
                     end
                     4'hc: acc_in = kbp_map(acc_ff);
                     4'hd: cmd_in = {cmd_ff[3], acc_ff[2:0]};
                     default: ;
                  endcase
               end
               default: ;
            endcase
         end
         pend_in = {pend_in[2:0], cmd_in[3]};
         cmd_in = {pend_in[3], cmd_in[2:0]};
      end
   end

   logic take;
   assign take = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         variant_ff <= 1'b0; acc_ff <= 4'd0; carry_ff <= 1'b0;
         for (int i = 0; i < STACK_DEPTH; i++) stack_ff[i] <= 12'd0;
         for (int i = 0; i < INDEX_PAIRS; i++) pairs_ff[i] <= 8'd0;
         sp_ff <= '0; bank_ff <= 1'b0; cmd_ff <= 4'd0; pend_ff <= 4'd0;
         ramaddr_ff <= 8'd0; kind_ff <= KIND_OP; held_ff <= 8'd0; fp_ff <= 12'd0;
         s1_valid_ff <= 1'b0; out_valid_ff <= 1'b0;
         clearing_ff <= 1'b1; clr_ff <= '0; fwd_ff <= 1'b0;
      end else begin
         if (csr_wr_en) variant_ff <= csr_wr_data;
         if (clearing_ff) begin
            clr_ff <= clr_ff + 1'b1;
            if (32'(clr_ff) == DATA_WORDS - 1) clearing_ff <= 1'b0;
         end
         if (exec) begin
            acc_ff <= acc_in; carry_ff <= carry_in; stack_ff <= stack_in;
            sp_ff <= sp_in; pairs_ff <= pairs_in; bank_ff <= bank_in;
            cmd_ff <= cmd_in; pend_ff <= pend_in; ramaddr_ff <= ramaddr_in;
            kind_ff <= kind_in; held_ff <= held_in; fp_ff <= fp_in;
         end
         fwd_ff <= ram_we && !clearing_ff && (ram_wa == ram_ra);
         if (exec) s1_valid_ff <= take;
         else if (take) s1_valid_ff <= 1'b1;
         if (exec) out_valid_ff <= 1'b1;
         else if (rsp_ready) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= ram_wd;
      if (take) begin
         s1_code_ff <= req_code_byte; s1_test_ff <= req_test_level;
         s1_pin_ff <= req_port_in;
      end
      if (exec) begin
         o_fa_ff <= ((variant_ff && cmd_in[3]) ? BANK_FLAG : 13'd0) |
                    {1'b0, fp_in & ADDR_MASK};
         o_kind_ff <= pk; o_pa_ff <= pa; o_pd_ff <= pd;
         o_acc_ff <= acc_in; o_c_ff <= carry_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_next_fetch_address = o_fa_ff;
   assign rsp_port_write_kind = o_kind_ff;
   assign rsp_port_address = o_pa_ff;
   assign rsp_port_data = o_pd_ff;
   assign rsp_accumulator_out = o_acc_ff;
   assign rsp_carry_out = o_c_ff;
endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// Testbench: nibble CPU executor checked against its own predictor, directed then random
module tb_top;
   import nce_pkg::*;

   localparam logic [3:0] OP_EXT = 4'h0, OP_JCN = 4'h1, OP_FIM = 4'h2, OP_FIN = 4'h3,
                          OP_JUN = 4'h4, OP_JMS = 4'h5, OP_INC = 4'h6, OP_ISZ = 4'h7,
                          OP_ADD = 4'h8, OP_SUB = 4'h9, OP_LD  = 4'ha, OP_XCH = 4'hb,
                          OP_BBL = 4'hc, OP_LDM = 4'hd, OP_IO  = 4'he, OP_ACC = 4'hf;
   localparam logic [3:0] IO_WRM = 4'h0, IO_WMP = 4'h1, IO_WRR = 4'h2, IO_WR0 = 4'h4,
                          IO_SBM = 4'h8, IO_RDM = 4'h9, IO_RDR = 4'ha, IO_ADM = 4'hb,
                          IO_RD0 = 4'hc;
   localparam logic [3:0] AC_CLB = 4'h0, AC_CLC = 4'h1, AC_IAC = 4'h2, AC_CMC = 4'h3,
                          AC_CMA = 4'h4, AC_RAL = 4'h5, AC_RAR = 4'h6, AC_TCC = 4'h7,
                          AC_DAC = 4'h8, AC_TCS = 4'h9, AC_STC = 4'ha, AC_DAA = 4'hb,
                          AC_KBP = 4'hc, AC_DCL = 4'hd;
   localparam logic [3:0] EX_LCR = 4'h3, EX_OR4 = 4'h4, EX_OR5 = 4'h5, EX_AN6 = 4'h6,
                          EX_AN7 = 4'h7, EX_DB0 = 4'h8, EX_DB1 = 4'h9, EX_SB0 = 4'ha,
                          EX_SB1 = 4'hb;
   localparam logic [3:0] KEY_CODE [16] = '{4'h0, 4'h1, 4'h2, 4'hf, 4'h3, 4'hf, 4'hf, 4'hf,
                                            4'h4, 4'hf, 4'hf, 4'hf, 4'hf, 4'hf, 4'hf, 4'hf};
   localparam int STK_MAX = 8, PAIRS = 12, RAM_WORDS = 2048, SETTLE = 8;

   typedef struct packed {
      logic [12:0]   nfa;
      port_kind_type kind;
      logic [11:0]   paddr;
      logic [3:0]    pdata;
      logic [3:0]    acc;
      logic          carry;
   } cycle_result_type;

   typedef struct {
      logic [7:0]       code;
      logic             test;
      logic [3:0]       pin;
      logic             typed;
      cycle_result_type want;
   } stim_row_type;

   logic        clock = 0, reset = 1;
   logic        csr_wr_en = 0, csr_wr_data = 0;
   logic        req_valid = 0, req_test_level = 0;
   logic [7:0]  req_code_byte = 0;
   logic [3:0]  req_port_in = 0;
   logic        rsp_ready = 0;
   logic        req_ready, rsp_valid, rsp_carry_out;
   logic [12:0] rsp_next_fetch_address;
   logic [1:0]  rsp_port_write_kind;
   logic [11:0] rsp_port_address;
   logic [3:0]  rsp_port_data, rsp_accumulator_out;

   nibble_cpu_instruction_executor_unit dut (
      .clock(clock), .reset(reset), .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_ready(req_ready), .req_code_byte(req_code_byte),
      .req_test_level(req_test_level), .req_port_in(req_port_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_next_fetch_address(rsp_next_fetch_address),
      .rsp_port_write_kind(rsp_port_write_kind), .rsp_port_address(rsp_port_address),
      .rsp_port_data(rsp_port_data), .rsp_accumulator_out(rsp_accumulator_out),
      .rsp_carry_out(rsp_carry_out)
   );

   always #1 clock = ~clock;

   // predictor state
   logic           mode;
   logic [3:0]     acc;
   logic           cy;
   logic [11:0]    stk [STK_MAX];
   logic [2:0]     sp;
   logic [7:0]     pairs [PAIRS];
   logic           bank;
   logic [3:0]     cmd, pend;
   logic [7:0]     ram_a;
   cycle_kind_type phase;
   logic [7:0]     held;
   logic [11:0]    fp;
   logic [7:0]     dram [RAM_WORDS];

   cycle_result_type results_due [$];
   stim_row_type     rows [$];
   int               mismatches = 0;
   int               send_idle = 0, recv_idle = 0;

   function automatic int stack_size();
      return mode ? STK_MAX : 4;
   endfunction

   function automatic int slot(input int n);
      int idx;
      idx = n & 7;
      if (idx < 4 && bank && mode && idx + 8 < PAIRS) idx += 8;
      return idx;
   endfunction

   function automatic logic [3:0] reg_rd(input int n);
      logic [7:0] p;
      p = pairs[slot(n >> 1)];
      return (n & 1) ? p[3:0] : p[7:4];
   endfunction

   function automatic void reg_wr(input int n, input int v);
      int s;
      s = slot(n >> 1);
      if (n & 1) pairs[s][3:0] = v[3:0];
      else pairs[s][7:4] = v[3:0];
   endfunction

   function automatic void acc_wr(input int v);
      acc = v[3:0];
      cy = v[4];
   endfunction

   function automatic void pc_wr(input int addr, input int mask);
      int pc;
      pc = stk[sp];
      pc = ((addr & mask) | (pc & ~mask)) & ADDR_MASK;
      stk[sp] = pc[11:0];
      fp = pc[11:0];
   endfunction

   function automatic int char_idx();
      return ((int'(cmd[2:0]) << 8) | ram_a) % RAM_WORDS;
   endfunction

   function automatic int stat_idx(input logic [3:0] opa);
      return ((((int'(cmd) << 8) | ram_a) & STATUS_MASK) | (opa & 3)) % RAM_WORDS;
   endfunction

   function automatic cycle_kind_type first_word(input logic [3:0] opr, input logic [3:0] opa);
      int d, v;
      case (opr)
         OP_EXT: if (mode) begin
            case (opa)
               EX_LCR: acc = cmd;
               EX_OR4, EX_OR5: acc = acc | reg_rd(4 | (opa & 1));
               EX_AN6, EX_AN7: acc = acc & reg_rd(6 | (opa & 1));
               EX_DB0, EX_DB1: pend[0] = opa[0];
               EX_SB0, EX_SB1: bank = opa[0];
               default: ;
            endcase
         end
         OP_JCN, OP_JUN, OP_JMS, OP_ISZ: return KIND_IM;
         OP_FIM: begin
            if (!opa[0]) return KIND_IM;
            ram_a = pairs[slot(opa >> 1)];
         end
         OP_FIN: begin
            if (!opa[0]) begin
               fp = {fp[11:8], pairs[slot(0)]};
               return KIND_IN;
            end
            pc_wr(pairs[slot(opa >> 1)], 'hff);
         end
         OP_INC: reg_wr(opa, reg_rd(opa) + 1);
         OP_ADD: acc_wr(acc + reg_rd(opa) + cy);
         OP_SUB: acc_wr(acc + (reg_rd(opa) ^ 4'hf) + (cy ^ 1'b1));
         OP_LD: acc = reg_rd(opa);
         OP_XCH: begin
            v = acc;
            acc = reg_rd(opa);
            reg_wr(opa, v);
         end
         OP_BBL: begin
            d = stack_size();
            sp = (sp == 0) ? 3'(d - 1) : sp - 1;
            fp = stk[sp];
            acc = opa;
         end
         OP_LDM: acc = opa;
         OP_ACC: case (opa)
            AC_CLB: begin acc = 0; cy = 0; end
            AC_CLC: cy = 0;
            AC_IAC: acc_wr(acc + 1);
            AC_CMC: cy = ~cy;
            AC_CMA: acc = ~acc;
            AC_RAL: acc_wr((int'(acc) << 1) | cy);
            AC_RAR: begin
               v = acc[0];
               acc = {cy, acc[3:1]};
               cy = v[0];
            end
            AC_TCC: begin acc = cy; cy = 0; end
            AC_DAC: acc_wr(acc + 15);
            AC_TCS: begin acc = DAA_LIMIT + cy; cy = 0; end
            AC_STC: cy = 1;
            AC_DAA: if (cy || acc > DAA_LIMIT) begin
               v = acc + DAA_ADJUST;
               acc = v[3:0];
               if (v[4]) cy = 1;
            end
            AC_KBP: acc = KEY_CODE[acc];
            AC_DCL: cmd = {cmd[3], acc[2:0]};
            default: ;
         endcase
         default: ;
      endcase
      return KIND_OP;
   endfunction

   function automatic void second_word(input logic [3:0] opr, input logic [3:0] opa,
                                       input logic [7:0] arg, input logic test);
      logic jump;
      logic [3:0] v;
      case (opr)
         OP_JCN: begin
            jump = (opa[0] && !test) || (opa[1] && cy) || (opa[2] && acc == 0);
            if (opa[3] != jump) pc_wr(arg, 'hff);
         end
         OP_FIM: pairs[slot(opa >> 1)] = arg;
         OP_JUN: pc_wr({opa, arg}, ADDR_MASK);
         OP_JMS: begin
            sp = (sp + 1 >= stack_size()) ? 0 : sp + 1;
            pc_wr({opa, arg}, ADDR_MASK);
         end
         OP_ISZ: begin
            v = reg_rd(opa) + 1;
            reg_wr(opa, v);
            if (v != 0) pc_wr(arg, 'hff);
         end
         default: ;
      endcase
   endfunction

   function automatic cycle_result_type predict_cycle(input logic [7:0] code,
                                                      input logic test,
                                                      input logic [3:0] pin);
      cycle_result_type r;
      int mi, si;
      logic [3:0] mem;
      r = '0;
      r.kind = PORT_NONE;
      if (sp >= stack_size()) sp = sp - 3'(stack_size());
      if (phase == KIND_IM) begin
         stk[sp] = stk[sp] + 1;
         fp = stk[sp];
         second_word(held[7:4], held[3:0], code, test);
         phase = KIND_OP;
      end else if (phase == KIND_IN) begin
         pairs[slot(held[3:1])] = code;
         fp = stk[sp];
         phase = KIND_OP;
      end else begin
         held = code;
         stk[sp] = stk[sp] + 1;
         fp = stk[sp];
         phase = first_word(code[7:4], code[3:0]);
         if (code[7:4] == OP_IO) begin
            mi = char_idx();
            mem = dram[mi][3:0];
            case (code[3:0])
               IO_WRM: dram[mi][3:0] = acc;
               IO_WMP, IO_WRR: begin
                  r.kind = (code[3:0] == IO_WMP) ? PORT_RAM : PORT_ROM;
                  r.paddr = {cmd, ram_a};
                  r.pdata = acc;
               end
               4'h4, 4'h5, 4'h6, 4'h7: begin
                  si = stat_idx(code[3:0]);
                  dram[si][7:4] = acc;
               end
               IO_SBM: acc_wr(acc + (mem ^ 4'hf) + (cy ^ 1'b1));
               IO_RDM: acc = mem;
               IO_RDR: acc = pin;
               IO_ADM: acc_wr(acc + mem + cy);
               4'hc, 4'hd, 4'he, 4'hf: acc = dram[stat_idx(code[3:0])][7:4];
               default: ;
            endcase
         end
      end
      pend = {pend[2:0], cmd[3]};
      cmd[3] = pend[3];
      r.nfa = ((mode && cmd[3]) ? BANK_FLAG : 13'h0) | fp;
      r.acc = acc;
      r.carry = cy;
      return r;
   endfunction

   task automatic send(input logic [7:0] code, input logic test, input logic [3:0] pin,
                       input logic typed, input cycle_result_type want);
      cycle_result_type r;
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_code_byte <= code;
      req_test_level <= test;
      req_port_in <= pin;
      do @(posedge clock); while (!(req_valid && req_ready));
      r = predict_cycle(code, test, pin);
      results_due.push_back(typed ? want : r);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_mode(input logic m);
      @(negedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= m;
      @(negedge clock);
      csr_wr_en <= 0;
      mode = m;
   endtask

   function automatic logic [7:0] random_code();
      int pick;
      pick = $urandom_range(99);
      if (pick < 20) return {OP_IO, 4'($urandom)};
      if (pick < 35) return {OP_ACC, 4'($urandom)};
      if (pick < 45) return {OP_EXT, 4'($urandom)};
      return 8'($urandom);
   endfunction

   task automatic random_phase(input int count, input int s_idle, input int r_idle);
      send_idle = s_idle;
      recv_idle = r_idle;
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) drain();
         send(random_code(), 1'($urandom), 4'($urandom), 0, '0);
      end
      drain();
   endtask

   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_idle);

   always @(posedge clock) begin
      cycle_result_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_next_fetch_address, port_kind_type'(rsp_port_write_kind),
                 rsp_port_address, rsp_port_data, rsp_accumulator_out, rsp_carry_out};
         if (results_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transfer out: %p", got);
         end else begin
            want = results_due.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch at %0t: expected %p, got %p", $realtime, want, got);
            end
         end
      end
   end

   initial begin
      #2000000;
      $display("FAIL nibble_cpu_instruction_executor_unit");
      $finish;
   end

   initial begin
      mode = 0; acc = 0; cy = 0; sp = 0; bank = 0; cmd = 0; pend = 0; ram_a = 0;
      phase = KIND_OP; held = 0; fp = 0;
      foreach (stk[i]) stk[i] = 0;
      foreach (pairs[i]) pairs[i] = 0;
      foreach (dram[i]) dram[i] = 0;

      rows = '{
         '{8'h00, 0, 4'h0, 1, '{13'd1, PORT_NONE, 12'h0, 4'h0, 4'h0, 1'b0}},
         '{{OP_LDM, 4'hf}, 0, 4'h0, 1, '{13'd2, PORT_NONE, 12'h0, 4'h0, 4'hf, 1'b0}},
         '{{OP_ACC, AC_IAC}, 0, 4'h0, 1, '{13'd3, PORT_NONE, 12'h0, 4'h0, 4'h0, 1'b1}},
         '{{OP_IO, IO_WRR}, 0, 4'h0, 1, '{13'd4, PORT_ROM, 12'h0, 4'h0, 4'h0, 1'b1}},
         '{{OP_FIM, 4'h2}, 0, 4'h0, 0, '0}, '{8'hab, 0, 4'h0, 0, '0},
         '{{OP_FIM, 4'h3}, 0, 4'h0, 0, '0},
         '{{OP_LDM, 4'h9}, 0, 4'h0, 0, '0}, '{{OP_IO, IO_WRM}, 0, 4'h0, 0, '0},
         '{{OP_IO, IO_WR0}, 0, 4'h0, 0, '0}, '{{OP_IO, IO_WMP}, 0, 4'h0, 0, '0},
         '{{OP_IO, IO_RDR}, 0, 4'hf, 0, '0}, '{{OP_IO, IO_ADM}, 0, 4'h0, 0, '0},
         '{{OP_IO, IO_RD0}, 0, 4'h0, 0, '0}, '{{OP_ACC, AC_DAA}, 0, 4'h0, 0, '0},
         '{{OP_ACC, AC_KBP}, 0, 4'h0, 0, '0}, '{{OP_ACC, AC_RAR}, 0, 4'h0, 0, '0},
         '{{OP_JMS, 4'hf}, 0, 4'h0, 0, '0}, '{8'hff, 0, 4'h0, 0, '0},
         '{{OP_BBL, 4'h5}, 0, 4'h0, 0, '0},
         '{{OP_FIN, 4'h0}, 0, 4'h0, 0, '0}, '{8'h5a, 0, 4'h0, 0, '0},
         '{{OP_JCN, 4'h9}, 1, 4'h0, 0, '0}, '{8'h40, 1, 4'h0, 0, '0},
         '{{OP_ISZ, 4'h0}, 0, 4'h0, 0, '0}, '{8'h10, 0, 4'h0, 0, '0}
      };

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      set_mode(0);
      foreach (rows[i]) send(rows[i].code, rows[i].test, rows[i].pin, rows[i].typed,
                             rows[i].want);
      drain();

      set_mode(1);
      random_phase(500, 33, 76);
      set_mode(0);
      random_phase(500, 76, 33);
      set_mode(1);
      random_phase(500, 0, 0);

      if (mismatches == 0)
         $display("PASS nibble_cpu_instruction_executor_unit");
      else
         $display("FAIL nibble_cpu_instruction_executor_unit");
      $finish;
   end

endmodule
